FILE: sv/pps_pkg.sv
// shared types and constants for the potentiometer position scaler
`default_nettype none

package pps_pkg;

    localparam int SAMPLE_BITS_DEF = 10;

    localparam int CODE_W = 10;
    localparam int POS_W  = 8;

    // quotient magnitude bits, larger values saturate
    localparam int DIV_STAGES = 3;
    localparam int DIV_STEPS  = 3;
    localparam int Q_W        = DIV_STAGES * DIV_STEPS;

    // remainder width: divisor below 2**CODE_W times 2**Q_W
    localparam int R_W = CODE_W + Q_W;

    // signed sum of offset and quotient
    localparam int VAL_W = Q_W + 2;

    localparam int SHIFT_FULL = 8;
    localparam int SHIFT_HALF = 7;

    localparam logic [CODE_W-1:0] MIN_RESET = 10'd0;
    localparam logic [CODE_W-1:0] MID_RESET = 10'd511;
    localparam logic [CODE_W-1:0] MAX_RESET = 10'd1023;

    localparam logic [POS_W-1:0] POS_MAX    = 8'd255;
    localparam logic [POS_W-1:0] MID_OFFSET = 8'd127;

    localparam int CFG_IDX_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_CODE    = 4'd0,
        REG_MID_CODE    = 4'd1,
        REG_MAX_CODE    = 4'd2,
        REG_TWO_SEGMENT = 4'd3
    } pps_reg_idx_t;

    typedef struct packed {
        logic              valid;
        logic              zero;
        logic              neg;
        logic              seg_hi;
        logic              ovf;
        logic [CODE_W-1:0] den;
        logic [R_W-1:0]    rem;
        logic [Q_W-1:0]    quo;
    } pps_stage_t;

endpackage

`default_nettype wire

FILE: sv/pps_prep.sv
// front stage: segment selection, signed differences, magnitudes and range check
`default_nettype none

module pps_prep #(
    parameter int SAMPLE_BITS = pps_pkg::SAMPLE_BITS_DEF
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       in_valid,
    input  wire [SAMPLE_BITS-1:0]     sample,
    input  wire [pps_pkg::CODE_W-1:0] min_code,
    input  wire [pps_pkg::CODE_W-1:0] mid_code,
    input  wire [pps_pkg::CODE_W-1:0] max_code,
    input  wire                       two_segment,
    output pps_pkg::pps_stage_t       stage_out
);
    import pps_pkg::*;

    localparam int MAG_W  = (SAMPLE_BITS > CODE_W) ? SAMPLE_BITS : CODE_W;
    localparam int DIFF_W = MAG_W + 1;
    localparam int A_W    = (MAG_W + SHIFT_FULL > R_W) ? MAG_W + SHIFT_FULL : R_W;

    logic [MAG_W-1:0]  s_u;
    logic [MAG_W-1:0]  lo_u;
    logic [MAG_W-1:0]  mid_u;
    logic [MAG_W-1:0]  num_base;
    logic [CODE_W-1:0] den_a;
    logic [CODE_W-1:0] den_b;
    logic              half;
    logic              seg_hi;
    logic [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0] diff_neg;
    logic [CODE_W:0]   den;
    logic [CODE_W:0]   den_neg;
    logic [MAG_W-1:0]  mag;
    logic [CODE_W-1:0] den_mag;
    logic [A_W-1:0]    num_abs;
    logic [A_W-1:0]    den_lim;
    pps_stage_t        stage_next;
    pps_stage_t        stage_reg;

    always_comb
    begin
        s_u   = MAG_W'(sample);
        lo_u  = MAG_W'(min_code);
        mid_u = MAG_W'(mid_code);

        // pick the segment and its span
        if (!two_segment)
        begin
            num_base = lo_u;
            den_a    = max_code;
            den_b    = min_code;
            half     = 1'b0;
            seg_hi   = 1'b0;
        end
        else if (s_u < mid_u)
        begin
            num_base = lo_u;
            den_a    = mid_code;
            den_b    = min_code;
            half     = 1'b1;
            seg_hi   = 1'b0;
        end
        else
        begin
            num_base = mid_u;
            den_a    = max_code;
            den_b    = mid_code;
            half     = 1'b1;
            seg_hi   = 1'b1;
        end

        diff     = {1'b0, s_u} - {1'b0, num_base};
        diff_neg = -diff;
        den      = {1'b0, den_a} - {1'b0, den_b};
        den_neg  = -den;
        mag      = diff[DIFF_W-1] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
        den_mag  = den[CODE_W] ? den_neg[CODE_W-1:0] : den[CODE_W-1:0];

        num_abs = half ? (A_W'(mag) << SHIFT_HALF) : (A_W'(mag) << SHIFT_FULL);
        den_lim = A_W'(den_mag) << Q_W;

        stage_next.valid  = in_valid;
        stage_next.zero   = (den == '0);
        stage_next.neg    = diff[DIFF_W-1] ^ den[CODE_W];
        stage_next.seg_hi = seg_hi;
        // quotient too big for the divider: saturate later
        stage_next.ovf    = (num_abs >= den_lim);
        stage_next.den    = den_mag;
        stage_next.rem    = num_abs[R_W-1:0];
        stage_next.quo    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

`default_nettype wire

FILE: sv/pps_div_stage.sv
// one pipeline stage of the restoring divider, a few quotient bits per stage
`default_nettype none

module pps_div_stage #(
    parameter int FIRST_BIT = pps_pkg::Q_W - 1
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  pps_pkg::pps_stage_t stage_in,
    output pps_pkg::pps_stage_t stage_out
);
    import pps_pkg::*;

    logic [R_W-1:0] rem;
    logic [R_W-1:0] trial;
    logic [Q_W-1:0] quo;
    pps_stage_t     stage_next;
    pps_stage_t     stage_reg;

    always_comb
    begin
        rem   = stage_in.rem;
        quo   = stage_in.quo;
        trial = '0;
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            trial = R_W'(stage_in.den) << (FIRST_BIT - j);
            if (rem >= trial)
            begin
                rem                = rem - trial;
                quo[FIRST_BIT - j] = 1'b1;
            end
        end
        stage_next     = stage_in;
        stage_next.rem = rem;
        stage_next.quo = quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

`default_nettype wire

FILE: sv/pps_post.sv
// back stage: sign, segment offset, clamp and result register
`default_nettype none

module pps_post (
    input  wire                      clk,
    input  wire                      rst_n,
    input  pps_pkg::pps_stage_t      stage_in,
    output logic                     done,
    output logic [pps_pkg::POS_W-1:0] position,
    output logic                     zero_span
);
    import pps_pkg::*;

    logic [Q_W-1:0]          q_eff;
    logic signed [VAL_W-1:0] off;
    logic signed [VAL_W-1:0] val;
    logic [POS_W-1:0]        position_next;
    logic                    done_reg;
    logic [POS_W-1:0]        position_reg;
    logic                    zero_span_reg;

    always_comb
    begin
        q_eff = stage_in.ovf ? '1 : stage_in.quo;
        off   = stage_in.seg_hi ? $signed(VAL_W'(MID_OFFSET)) : '0;
        if (stage_in.neg)
        begin
            val = off - $signed(VAL_W'(q_eff));
        end
        else
        begin
            val = off + $signed(VAL_W'(q_eff));
        end

        if (stage_in.zero || val[VAL_W-1])
        begin
            position_next = '0;
        end
        else if (val > $signed(VAL_W'(POS_MAX)))
        begin
            position_next = POS_MAX;
        end
        else
        begin
            position_next = val[POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        position_reg  <= position_next;
        zero_span_reg <= stage_in.zero;
    end

    assign done      = done_reg;
    assign position  = position_reg;
    assign zero_span = zero_span_reg;

endmodule

`default_nettype wire

FILE: sv/pot_position_scaler_unit.sv
// top level of the potentiometer position scaler
//
//  port group        direction  handshake           payload
//  item in           in         start / busy        sample
//  result out        out        done (one cycle)    position, zero_span
//  calibration       in         cfg_write           cfg_index, cfg_data
//
// one item per clock; busy stays low, start may be high every cycle
// done and the result come from the back stage register; an item passes the front stage register,
// three divider stages of three quotient bits each, and then the back stage
// reset clears the pipeline valid bits and loads the default calibration
// the receiver cannot stall: every result is shown for exactly one cycle
`default_nettype none

module pot_position_scaler_unit #(
    parameter int SAMPLE_BITS = pps_pkg::SAMPLE_BITS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire [SAMPLE_BITS-1:0]        sample,
    output logic                         done,
    output logic [pps_pkg::POS_W-1:0]    position,
    output logic                         zero_span,
    input  wire                          cfg_write,
    input  wire [pps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire [pps_pkg::CODE_W-1:0]    cfg_data
);
    import pps_pkg::*;

    // calibration registers
    logic [CODE_W-1:0] min_code_reg;
    logic [CODE_W-1:0] mid_code_reg;
    logic [CODE_W-1:0] max_code_reg;
    logic              two_segment_reg;

    // pipeline stages: front, divider stages, back
    pps_stage_t        div_stage[DIV_STAGES+1];

    logic              accept;

    // never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // writes to unused indexes fall through and are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_code_reg    <= MIN_RESET;
            mid_code_reg    <= MID_RESET;
            max_code_reg    <= MAX_RESET;
            two_segment_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MIN_CODE:    min_code_reg    <= cfg_data;
                REG_MID_CODE:    mid_code_reg    <= cfg_data;
                REG_MAX_CODE:    max_code_reg    <= cfg_data;
                REG_TWO_SEGMENT: two_segment_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // segment choice, differences and saturation check
    pps_prep #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .sample     (sample),
        .min_code   (min_code_reg),
        .mid_code   (mid_code_reg),
        .max_code   (max_code_reg),
        .two_segment(two_segment_reg),
        .stage_out  (div_stage[0])
    );

    // divider: highest quotient bits first
    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        pps_div_stage #(
            .FIRST_BIT(Q_W - 1 - g * DIV_STEPS)
        ) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .stage_in (div_stage[g]),
            .stage_out(div_stage[g+1])
        );
    end

    // sign, offset and clamp into the result register
    pps_post u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .stage_in (div_stage[DIV_STAGES]),
        .done     (done),
        .position (position),
        .zero_span(zero_span)
    );

endmodule

`default_nettype wire

FILE: sv/pps_checker.sv
// port-level checks for the position scaler, bound to the top level
`default_nettype none

module pps_checker (
    input wire                      clk,
    input wire                      rst_n,
    input wire                      start,
    input wire                      busy,
    input wire                      done,
    input wire [pps_pkg::POS_W-1:0] position,
    input wire                      zero_span,
    input wire                      cfg_write
);
    import pps_pkg::*;

    // every taken item is followed by a result strobe
    a_item_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("item taken without a result five cycles later");

    // no result without a matching taken item
    a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(rst_n, 5)) |-> $past(start && !busy, 5))
        else $error("result strobe without a matching item");

    // a zero span always reports position zero
    a_zero_span_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_span) |-> (position == '0))
        else $error("zero span with non-zero position");

    // the pipeline stays ready to take items after a calibration write
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cfg_write) |-> !busy)
        else $error("busy raised after a calibration write");

endmodule

bind pot_position_scaler_unit pps_checker u_pps_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_top.sv
// testbench for the potentiometer position scaler: calibration phases, directed and random items
`timescale 1ns / 1ps

module tb_top;

    import pps_pkg::*;

    localparam int SB           = SAMPLE_BITS_DEF;
    localparam int CODE_MAX     = (1 << CODE_W) - 1;
    localparam int FULL_SCALE   = 256;
    localparam int HALF_SCALE   = 128;
    localparam int IDLE_PCT     = 31;
    localparam int RESET_CYCLES = 12;
    // idle time after the last result, before the final check
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 14;
    localparam int PHASE_ITEMS  = 90;
    localparam int NOIDLE_PHASE = 6;

    // register indexes past the last real one, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = '1;

    typedef struct {
        logic [POS_W-1:0] position;
        logic             zero_span;
    } position_t;

    // keeps its own copy of the calibration and the positions still owed by the block
    class position_checker;
        logic [CODE_W-1:0] min_code;
        logic [CODE_W-1:0] mid_code;
        logic [CODE_W-1:0] max_code;
        logic              two_segment;
        position_t         owed[$];
        int                mismatches;

        function new();
            min_code    = MIN_RESET;
            mid_code    = MID_RESET;
            max_code    = MAX_RESET;
            two_segment = 1'b0;
            mismatches  = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CODE_W-1:0] data);
            case (idx)
                REG_MIN_CODE:    min_code = data;
                REG_MID_CODE:    mid_code = data;
                REG_MAX_CODE:    max_code = data;
                REG_TWO_SEGMENT: two_segment = data[0];
                default:         ;
            endcase
        endfunction

        // signed piecewise scaling, division truncating toward zero, then clamp
        function void note_sample(logic [SB-1:0] value);
            int        s;
            int        lo;
            int        md;
            int        hi;
            int        num;
            int        den;
            int        ofs;
            int        q;
            position_t r;
            s   = int'(value);
            lo  = int'(min_code);
            md  = int'(mid_code);
            hi  = int'(max_code);
            ofs = 0;
            if (!two_segment)
            begin
                num = (s - lo) * FULL_SCALE;
                den = hi - lo;
            end
            else if (s < md)
            begin
                num = (s - lo) * HALF_SCALE;
                den = md - lo;
            end
            else
            begin
                num = (s - md) * HALF_SCALE;
                den = hi - md;
                ofs = int'(MID_OFFSET);
            end
            if (den == 0)
            begin
                r.position  = '0;
                r.zero_span = 1'b1;
            end
            else
            begin
                q = num / den + ofs;
                if (q < 0)
                    q = 0;
                if (q > int'(POS_MAX))
                    q = int'(POS_MAX);
                r.position  = POS_W'(q);
                r.zero_span = 1'b0;
            end
            owed.push_back(r);
        endfunction

        function void check_position(logic [POS_W-1:0] pos, logic zs);
            position_t e;
            if (owed.size() == 0)
            begin
                $display("%0t: result with none owed, got position %0d zero_span %0b",
                         $time, pos, zs);
                mismatches++;
                return;
            end
            e = owed.pop_front();
            if (pos !== e.position)
            begin
                $display("%0t: position expected %0d got %0d", $time, e.position, pos);
                mismatches++;
            end
            if (zs !== e.zero_span)
            begin
                $display("%0t: zero_span expected %0b got %0b", $time, e.zero_span, zs);
                mismatches++;
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic [SB-1:0]        sample    = '0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CODE_W-1:0]    cfg_data  = '0;
    wire                  busy;
    wire                  done;
    wire [POS_W-1:0]      position;
    wire                  zero_span;

    position_checker chk;
    int              cycles = 0;

    pot_position_scaler_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .sample    (sample),
        .done      (done),
        .position  (position),
        .zero_span (zero_span),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // watchdog, generous against the slowest legal run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // observe the ports at the edge: register writes, accepted items, results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
                chk.set_register(cfg_index, cfg_data);
            if (start && !busy)
                chk.note_sample(sample);
            if (done)
                chk.check_position(position, zero_span);
        end
    end

    // offer one item, idling first at random, and hold it until taken
    task automatic send_item(input logic [SB-1:0] value, input bit idle_on);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        sample <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // every item gives a result, so an empty queue means an idle pipeline;
    // the task waits on the clock first so the item taken at the caller's edge is already noted
    task automatic wait_idle();
        @(posedge clk);
        while (chk.pending() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // one register write, the caller lowers the enable after the last one
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic calibrate(input logic [CODE_W-1:0] lo, input logic [CODE_W-1:0] md,
                             input logic [CODE_W-1:0] hi, input logic seg);
        start <= 1'b0;
        wait_idle();
        reg_write(REG_MIN_CODE, lo);
        reg_write(REG_MID_CODE, md);
        reg_write(REG_MAX_CODE, hi);
        reg_write(REG_TWO_SEGMENT, {{(CODE_W-1){1'b0}}, seg});
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // mostly samples around the calibrated span and the centre, some anywhere
    function automatic logic [SB-1:0] pick_sample(int lo, int md, int hi);
        int a;
        int b;
        int pick;
        pick = $urandom_range(0, 99);
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        if (pick < 20)
            return SB'($urandom_range(0, CODE_MAX));
        if (pick < 35)
        begin
            a = md;
            b = md;
        end
        a = (a < 8) ? 0 : a - 8;
        b = (b > CODE_MAX - 8) ? CODE_MAX : b + 8;
        return SB'($urandom_range(a, b));
    endfunction

    initial
    begin
        logic [CODE_W-1:0] lo;
        logic [CODE_W-1:0] md;
        logic [CODE_W-1:0] hi;
        logic [CODE_W-1:0] t;
        logic              seg;
        int                kind;

        chk = new();
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset calibration, single span: both ends, centre and neighbours
        send_item('0, 1'b1);
        send_item(SB'(CODE_MAX), 1'b1);
        send_item(SB'(511), 1'b1);
        send_item(SB'(1), 1'b1);
        // two-segment on defaults, either side of the centre code
        calibrate(MIN_RESET, MID_RESET, MAX_RESET, 1'b1);
        send_item('0, 1'b1);
        send_item(SB'(510), 1'b1);
        send_item(SB'(511), 1'b1);
        send_item(SB'(CODE_MAX), 1'b1);
        // zero span in single mode
        calibrate(10'd300, 10'd500, 10'd300, 1'b0);
        send_item(SB'(300), 1'b1);
        send_item('0, 1'b1);
        // zero span on the lower segment only, then the upper one only
        calibrate(10'd400, 10'd400, 10'd800, 1'b1);
        send_item(SB'(100), 1'b1);
        send_item(SB'(400), 1'b1);
        calibrate(10'd100, 10'd600, 10'd600, 1'b1);
        send_item(SB'(700), 1'b1);
        send_item(SB'(50), 1'b1);
        // reversed calibration, both modes
        calibrate(10'd1000, 10'd500, 10'd20, 1'b0);
        send_item('0, 1'b1);
        send_item(SB'(CODE_MAX), 1'b1);
        calibrate(10'd1000, 10'd500, 10'd20, 1'b1);
        send_item(SB'(300), 1'b1);
        send_item(SB'(800), 1'b1);
        // samples beyond the calibrated range clamp at both ends
        calibrate(10'd200, 10'd450, 10'd700, 1'b0);
        send_item(SB'(100), 1'b1);
        send_item(SB'(900), 1'b1);
        // writes to unused indexes are dropped, mode keeps only its low bit
        start <= 1'b0;
        wait_idle();
        reg_write(REG_FIRST_UNUSED, '0);
        reg_write(REG_LAST_UNUSED, '1);
        reg_write(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
                  CODE_W'($urandom_range(0, CODE_MAX)));
        reg_write(REG_TWO_SEGMENT, 10'h3FE);
        cfg_write <= 1'b0;
        @(posedge clk);
        send_item(SB'(600), 1'b1);
        start <= 1'b0;
        wait_idle();
        reg_write(REG_TWO_SEGMENT, 10'h3FF);
        cfg_write <= 1'b0;
        @(posedge clk);
        send_item(SB'(300), 1'b1);

        // random phases, the first few on extreme calibrations
        for (int p = 0; p < PHASES; p++)
        begin
            seg  = $urandom_range(0, 1);
            kind = $urandom_range(0, 99);
            case (p)
                0:
                begin
                    lo = '0;
                    md = MID_RESET;
                    hi = '1;
                end
                1:
                begin
                    lo = '1;
                    md = MID_RESET;
                    hi = '0;
                end
                2:
                begin
                    lo = '0;
                    md = '0;
                    hi = '1;
                end
                3:
                begin
                    lo = '0;
                    md = '1;
                    hi = '1;
                end
                default:
                begin
                    lo = CODE_W'($urandom_range(0, CODE_MAX));
                    md = CODE_W'($urandom_range(0, CODE_MAX));
                    hi = CODE_W'($urandom_range(0, CODE_MAX));
                    if (kind < 65)
                    begin
                        // well-formed: sort into min, centre, max
                        if (lo > md)
                        begin
                            t  = lo;
                            lo = md;
                            md = t;
                        end
                        if (md > hi)
                        begin
                            t  = md;
                            md = hi;
                            hi = t;
                        end
                        if (lo > md)
                        begin
                            t  = lo;
                            lo = md;
                            md = t;
                        end
                    end
                    else if (kind < 80)
                        md = (kind < 72) ? lo : hi;
                end
            endcase
            calibrate(lo, md, hi, seg);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_item(pick_sample(int'(lo), int'(md), int'(hi)), p != NOIDLE_PHASE);
        end

        start <= 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (chk.mismatches == 0 && chk.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
sv/pps_pkg.sv
sv/pps_prep.sv
sv/pps_div_stage.sv
sv/pps_post.sv
sv/pot_position_scaler_unit.sv
sv/pps_checker.sv
tb/sv/tb_top.sv
